[rtl/bsa_pkg.sv]
// Shared types, sizes and helper functions for the bitmap slot allocator.
// No dependencies; used by bsa_bitmap_store and bitmap_slot_allocator_core.
package bsa_pkg;

    localparam int WORD_BITS            = 32;
    localparam int BIT_IDX_W            = 5;
    localparam int MAX_WORDS            = 32;
    localparam int DEFAULT_BITMAP_WORDS = 32;
    localparam int SLOT_W               = 10;
    localparam int COUNT_W              = 11;
    localparam int MAX_SLOTS            = 1024;

    // Command codes carried on s_tuser
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [BIT_IDX_W-1:0] bit_idx_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [COUNT_W-1:0]   count_t;

    // Port strobes toward the bitmap store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    // Lowest clear bit of a word; returns 0 for an all-ones word
    function automatic bit_idx_t lowest_zero(input word_t w);
        bit_idx_t r;
        r = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (!w[b])
            begin
                r = BIT_IDX_W'(b);
            end
        end
        return r;
    endfunction

endpackage

[rtl/bitmap_slot_allocator_core.sv]
// Top level of the bitmap slot allocator: command handshake, read-modify-write
// sequencing and result register. Depends on bsa_pkg and bsa_bitmap_store.
//
// The allocator tracks up to 1024 slots as a bitmap of 32-bit words held in a
// synchronous memory, plus a one-flop-per-word summary of which words are full.
// Each transaction on the slave side is one request: s_tuser = 0 allocates the
// lowest-numbered free slot, s_tuser = 1 releases the slot in s_tdata. Every
// request yields exactly one result transaction carrying the granted slot, a
// pool-full flag and the in-use count after the request. The accept cycle
// issues the memory read of the one word concerned (chosen from the full
// summary for an allocate), and the next cycle modifies that word, writes it
// back and loads the result register. The memory's single read-modify-write
// per request blocks the next request until done; s_tready stays low during
// the modify cycle and while it waits for a stalled result to drain. The
// bitmap is free at reset with no clearing pass: per-word valid bits make any
// unwritten word read as empty. Releasing a slot outside the pool changes
// nothing; releasing a free slot still decrements the count, saturating at 0.
module bitmap_slot_allocator_core #(
    parameter int BITMAP_WORDS = bsa_pkg::DEFAULT_BITMAP_WORDS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] slot_to_free, [15:10] zero
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [9:0] granted_slot, [20:10] slots_in_use, [23:21] zero
    output logic        m_tuser    // [0] pool_full
);

    // Slot indices are 10 bits, so only the first 32 words are reachable
    localparam int ACTIVE_WORDS = (BITMAP_WORDS < bsa_pkg::MAX_WORDS) ?
                                  BITMAP_WORDS : bsa_pkg::MAX_WORDS;
    localparam int WIDX_W       = (ACTIVE_WORDS > 1) ? $clog2(ACTIVE_WORDS) : 1;
    localparam int POOL_SLOTS   = ACTIVE_WORDS * bsa_pkg::WORD_BITS;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_MODIFY = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic                cmd_reg, cmd_next;
    logic                ok_reg, ok_next;
    logic [WIDX_W-1:0]   addr_reg, addr_next;
    bsa_pkg::bit_idx_t   bit_reg, bit_next;
    bsa_pkg::count_t     count_reg, count_next;

    logic                out_valid_reg, out_valid_next;
    bsa_pkg::slot_t      out_slot_reg, out_slot_next;
    logic                out_full_reg, out_full_next;
    bsa_pkg::count_t     out_count_reg, out_count_next;

    bsa_pkg::mem_ctl_t   mem_ctl;
    logic [WIDX_W-1:0]   rd_addr;
    bsa_pkg::word_t      rd_data;
    bsa_pkg::word_t      wr_data;
    logic [ACTIVE_WORDS-1:0] word_full;

    logic                s_accept;
    logic                out_free;
    logic                any_free;
    logic [WIDX_W-1:0]   first_free;
    logic                in_range;
    logic                req_ok;
    logic [WIDX_W-1:0]   req_addr;
    bsa_pkg::bit_idx_t   alloc_bit;

    bsa_bitmap_store #(
        .WORDS  (ACTIVE_WORDS),
        .WIDX_W (WIDX_W)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (mem_ctl),
        .rd_addr   (rd_addr),
        .wr_addr   (addr_reg),
        .wr_data   (wr_data),
        .rd_data   (rd_data),
        .word_full (word_full)
    );

    // Lowest word that still has a clear bit
    always_comb
    begin
        first_free = '0;
        any_free   = 1'b0;
        for (int i = ACTIVE_WORDS - 1; i >= 0; i--)
        begin
            if (!word_full[i])
            begin
                first_free = WIDX_W'(i);
                any_free   = 1'b1;
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Release word index must land inside the pool
    assign in_range = {1'b0, s_tdata[9:5]} < 6'(ACTIVE_WORDS);
    assign req_ok   = (s_tuser == bsa_pkg::CMD_ALLOC) ? any_free : in_range;
    assign req_addr = (s_tuser == bsa_pkg::CMD_ALLOC) ? first_free : s_tdata[5 +: WIDX_W];
    assign rd_addr  = req_addr;

    assign alloc_bit = bsa_pkg::lowest_zero(rd_data);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        ok_next        = ok_reg;
        addr_next      = addr_reg;
        bit_next       = bit_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_slot_next  = out_slot_reg;
        out_full_next  = out_full_reg;
        out_count_next = out_count_reg;
        mem_ctl.rd_en  = 1'b0;
        mem_ctl.wr_en  = 1'b0;
        wr_data        = rd_data;

        // Drain the result register
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    // Issue the read now; skip it when there is nothing to touch
                    mem_ctl.rd_en = req_ok;
                    cmd_next      = s_tuser;
                    ok_next       = req_ok;
                    addr_next     = req_addr;
                    bit_next      = s_tdata[4:0];
                    state_next    = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                if (cmd_reg == bsa_pkg::CMD_ALLOC)
                begin
                    wr_data = rd_data | (bsa_pkg::word_t'(1) << alloc_bit);
                end
                else
                begin
                    wr_data = rd_data & ~(bsa_pkg::word_t'(1) << bit_reg);
                end

                // Hold until the result register can take the answer
                if (out_free)
                begin
                    mem_ctl.wr_en  = ok_reg;
                    out_valid_next = 1'b1;
                    out_slot_next  = '0;
                    out_full_next  = 1'b0;
                    if (cmd_reg == bsa_pkg::CMD_ALLOC)
                    begin
                        if (ok_reg)
                        begin
                            out_slot_next = {5'(addr_reg), alloc_bit};
                            if (count_reg < bsa_pkg::COUNT_W'(bsa_pkg::MAX_SLOTS))
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            out_full_next = 1'b1;
                        end
                    end
                    else if (ok_reg && (count_reg != '0))
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    out_count_next = count_next;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and result payload, no reset needed
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        ok_reg        <= ok_next;
        addr_reg      <= addr_next;
        bit_reg       <= bit_next;
        out_slot_reg  <= out_slot_next;
        out_full_reg  <= out_full_next;
        out_count_reg <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_count_reg, out_slot_reg};
    assign m_tuser  = out_full_reg;

    // Reads and write-backs never share a cycle, so no bypass is needed
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_ctl.rd_en && mem_ctl.wr_en))
        else $error("bitmap read and write in the same cycle");

    // An accepted request always moves to the modify cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (state_reg == ST_MODIFY))
        else $error("accepted request did not enter modify");

    // Finishing a modify cycle leaves a result waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MODIFY) && out_free) |=> out_valid_reg)
        else $error("completed request produced no result");

    // A full pool never grants a slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_full_reg) |-> (out_slot_reg == '0))
        else $error("pool full result carries a slot");

    // The count cannot exceed the number of slots in the pool
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bsa_pkg::COUNT_W'(POOL_SLOTS))
        else $error("in-use count beyond pool size");

endmodule

[rtl/bsa_bitmap_store.sv]
// Bitmap word memory with per-word valid bits and a per-word full summary.
// Depends on bsa_pkg.
module bsa_bitmap_store #(
    parameter int WORDS  = bsa_pkg::DEFAULT_BITMAP_WORDS,
    parameter int WIDX_W = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bsa_pkg::mem_ctl_t     ctl,
    input  logic [WIDX_W-1:0]     rd_addr,
    input  logic [WIDX_W-1:0]     wr_addr,
    input  bsa_pkg::word_t        wr_data,
    output bsa_pkg::word_t        rd_data,
    output logic [WORDS-1:0]      word_full
);

    bsa_pkg::word_t   mem_reg [WORDS];
    bsa_pkg::word_t   rd_data_reg;
    logic             rd_valid_reg;
    logic [WORDS-1:0] word_valid_reg;
    logic [WORDS-1:0] word_full_reg;

    // Synchronous memory; the read data is registered
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= '0;
            word_full_reg  <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                word_valid_reg[wr_addr] <= 1'b1;
                word_full_reg[wr_addr]  <= &wr_data;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= word_valid_reg[rd_addr];
            end
        end
    end

    // A word never written since reset reads as all free
    assign rd_data   = rd_valid_reg ? rd_data_reg : '0;
    assign word_full = word_full_reg;

endmodule
